>>> rtl/core/button_mouse_motion_generator_defines.svh
// Assertion macros for the button mouse motion generator.
// Used by the top level; needs a clk and an active-low rst_n in scope.
`ifndef BUTTON_MOUSE_MOTION_GENERATOR_DEFINES_SVH
`define BUTTON_MOUSE_MOTION_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define BMMG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bmmg assertion failed");

// Property checked on every clock edge, reset included.
`define BMMG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bmmg assertion failed");

`else

`define BMMG_ASSERT(lbl, prop)
`define BMMG_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/core/bmmg_pkg.sv
// Shared types, constants and circle tables of the button mouse motion generator.
// No dependencies.
package bmmg_pkg;

  // Circle table geometry: one entry per 2 degrees.
  localparam int CIRCLE_STEPS = 180;
  localparam int ANGLE_W      = $clog2(CIRCLE_STEPS);

  // Configuration register widths and reset values.
  localparam int GAIN_W  = 7;
  localparam int STEP_W  = 10;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam logic [GAIN_W-1:0] START_GAIN_RST = 7'd3;
  localparam logic [GAIN_W-1:0] GAIN_CAP_RST   = 7'd30;
  localparam logic [STEP_W-1:0] STEP_MS_RST    = 10'd100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS    = 2'd2;

  // Saturation point of the hold step counters.
  localparam logic [GAIN_W-1:0] STEPS_MAX = '1;

  typedef struct packed {
    logic [GAIN_W-1:0] start_gain;
    logic [GAIN_W-1:0] gain_cap;
    logic [STEP_W-1:0] ms_per_gain_step;
  } bmmg_cfg_t;

  typedef struct packed {
    logic left_pressed;
    logic right_pressed;
    logic up_pressed;
    logic down_pressed;
    logic mode_pressed;
    logic report_due;
  } bmmg_in_t;

  typedef struct packed {
    logic              report_valid;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic              mode_led;
  } bmmg_out_t;

  // Truncated 10*sin and 10*cos, one entry per 2 degrees.
  localparam logic signed [4:0] SIN_TAB [CIRCLE_STEPS] = '{
    5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd1, 5'sd1, 5'sd2, 5'sd2, 5'sd2, 5'sd3,
    5'sd3, 5'sd3, 5'sd4, 5'sd4, 5'sd4, 5'sd4, 5'sd5, 5'sd5, 5'sd5, 5'sd6,
    5'sd6, 5'sd6, 5'sd6, 5'sd7, 5'sd7, 5'sd7, 5'sd7, 5'sd8, 5'sd8, 5'sd8,
    5'sd8, 5'sd8, 5'sd8, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9,
    5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9,
    5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd8, 5'sd8,
    5'sd8, 5'sd8, 5'sd8, 5'sd8, 5'sd7, 5'sd7, 5'sd7, 5'sd7, 5'sd6, 5'sd6,
    5'sd6, 5'sd6, 5'sd5, 5'sd5, 5'sd5, 5'sd5, 5'sd4, 5'sd4, 5'sd4, 5'sd3,
    5'sd3, 5'sd3, 5'sd2, 5'sd2, 5'sd2, 5'sd1, 5'sd1, 5'sd1, 5'sd0, 5'sd0,
    5'sd0, 5'sd0, 5'sd0, -5'sd1, -5'sd1, -5'sd1, -5'sd2, -5'sd2, -5'sd2, -5'sd3,
    -5'sd3, -5'sd3, -5'sd4, -5'sd4, -5'sd4, -5'sd4, -5'sd5, -5'sd5, -5'sd5, -5'sd6,
    -5'sd6, -5'sd6, -5'sd6, -5'sd7, -5'sd7, -5'sd7, -5'sd7, -5'sd8, -5'sd8, -5'sd8,
    -5'sd8, -5'sd8, -5'sd8, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9,
    -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9,
    -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd8, -5'sd8,
    -5'sd8, -5'sd8, -5'sd8, -5'sd8, -5'sd7, -5'sd7, -5'sd7, -5'sd7, -5'sd6, -5'sd6,
    -5'sd6, -5'sd6, -5'sd5, -5'sd5, -5'sd5, -5'sd5, -5'sd4, -5'sd4, -5'sd4, -5'sd3,
    -5'sd3, -5'sd3, -5'sd2, -5'sd2, -5'sd2, -5'sd1, -5'sd1, -5'sd1, 5'sd0, 5'sd0
  };

  localparam logic signed [4:0] COS_TAB [CIRCLE_STEPS] = '{
    5'sd10, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9,
    5'sd9, 5'sd9, 5'sd9, 5'sd8, 5'sd8, 5'sd8, 5'sd8, 5'sd8, 5'sd8, 5'sd7,
    5'sd7, 5'sd7, 5'sd7, 5'sd6, 5'sd6, 5'sd6, 5'sd6, 5'sd5, 5'sd5, 5'sd5,
    5'sd5, 5'sd4, 5'sd4, 5'sd4, 5'sd3, 5'sd3, 5'sd3, 5'sd2, 5'sd2, 5'sd2,
    5'sd1, 5'sd1, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, -5'sd1, -5'sd1,
    -5'sd1, -5'sd2, -5'sd2, -5'sd2, -5'sd3, -5'sd3, -5'sd3, -5'sd4, -5'sd4, -5'sd4,
    -5'sd4, -5'sd5, -5'sd5, -5'sd5, -5'sd6, -5'sd6, -5'sd6, -5'sd6, -5'sd7, -5'sd7,
    -5'sd7, -5'sd7, -5'sd8, -5'sd8, -5'sd8, -5'sd8, -5'sd8, -5'sd8, -5'sd9, -5'sd9,
    -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9,
    -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9, -5'sd9,
    -5'sd9, -5'sd9, -5'sd9, -5'sd8, -5'sd8, -5'sd8, -5'sd8, -5'sd8, -5'sd8, -5'sd7,
    -5'sd7, -5'sd7, -5'sd7, -5'sd6, -5'sd6, -5'sd6, -5'sd6, -5'sd5, -5'sd5, -5'sd5,
    -5'sd5, -5'sd4, -5'sd4, -5'sd4, -5'sd3, -5'sd3, -5'sd3, -5'sd2, -5'sd2, -5'sd2,
    -5'sd1, -5'sd1, -5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd1,
    5'sd1, 5'sd2, 5'sd2, 5'sd2, 5'sd3, 5'sd3, 5'sd3, 5'sd4, 5'sd4, 5'sd4,
    5'sd4, 5'sd5, 5'sd5, 5'sd5, 5'sd6, 5'sd6, 5'sd6, 5'sd6, 5'sd7, 5'sd7,
    5'sd7, 5'sd7, 5'sd8, 5'sd8, 5'sd8, 5'sd8, 5'sd8, 5'sd8, 5'sd9, 5'sd9,
    5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9, 5'sd9
  };

endpackage

>>> rtl/core/button_mouse_motion_generator.sv
// Button mouse motion generator: result registered in the cycle after input
// transfer. Throughput: one item per cycle unless the output is stalled; hold
// timers, mode toggle and circle table read feed the output register directly.
// Reset (rst_n low, synchronous): button mode, angle 0, hold timers and button
// history cleared, configuration back to base gain 3, cap 30, 100 ms per step.
`include "button_mouse_motion_generator_defines.svh"

module button_mouse_motion_generator
  import bmmg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bmmg_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bmmg_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  bmmg_cfg_t          cfg_r;
  logic [4:0]         prev_r;
  logic               mode_r, mode_nxt;
  logic [ANGLE_W-1:0] angle_r, angle_nxt;
  logic               out_valid_r;
  bmmg_out_t          out_data_r, out_data_nxt;
  logic               in_xfer;
  logic [3:0]         levels;
  logic [GAIN_W-1:0]  gain [4];

  // Output register is free when empty or being drained this cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_gain       <= START_GAIN_RST;
      cfg_r.gain_cap         <= GAIN_CAP_RST;
      cfg_r.ms_per_gain_step <= STEP_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_GAIN: cfg_r.start_gain       <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_CAP:   cfg_r.gain_cap         <= cfg_wdata[GAIN_W-1:0];
        CFG_STEP_MS:    cfg_r.ms_per_gain_step <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold timers, in order left, right, up, down.
  assign levels = {in_data.down_pressed, in_data.up_pressed,
                   in_data.right_pressed, in_data.left_pressed};

  for (genvar b = 0; b < 4; b++) begin : g_hold
    bmmg_hold u_hold (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (in_xfer),
      .level     (levels[b]),
      .prev_level(prev_r[b]),
      .cfg       (cfg_r),
      .gain      (gain[b])
    );
  end

  // Mode toggles on a rising edge of the mode button.
  assign mode_nxt = mode_r ^ (in_data.mode_pressed && !prev_r[4]);

  // Result of this tick, built from the updated mode and gains.
  always_comb begin
    angle_nxt                 = angle_r;
    out_data_nxt.report_valid = in_data.report_due;
    out_data_nxt.delta_x      = '0;
    out_data_nxt.delta_y      = '0;
    out_data_nxt.mode_led     = mode_nxt;
    if (in_data.report_due) begin
      if (!mode_nxt) begin
        if (in_data.right_pressed && !in_data.left_pressed) begin
          out_data_nxt.delta_x = $signed({1'b0, gain[1]});
        end else if (in_data.left_pressed && !in_data.right_pressed) begin
          out_data_nxt.delta_x = -$signed({1'b0, gain[0]});
        end
        if (in_data.down_pressed && !in_data.up_pressed) begin
          out_data_nxt.delta_y = $signed({1'b0, gain[3]});
        end else if (in_data.up_pressed && !in_data.down_pressed) begin
          out_data_nxt.delta_y = -$signed({1'b0, gain[2]});
        end
      end else begin
        out_data_nxt.delta_x = 8'(SIN_TAB[angle_r]);
        out_data_nxt.delta_y = 8'(COS_TAB[angle_r]);
        if (angle_r == ANGLE_W'(CIRCLE_STEPS - 1)) begin
          angle_nxt = '0;
        end else begin
          angle_nxt = angle_r + ANGLE_W'(1);
        end
      end
    end
  end

  // Tick state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      mode_r      <= 1'b0;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        prev_r      <= {in_data.mode_pressed, levels};
        mode_r      <= mode_nxt;
        angle_r     <= angle_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Outside reset, the angle always stays inside the table.
  `BMMG_ASSERT_ALWAYS(a_angle_range, !rst_n || angle_r < ANGLE_W'(CIRCLE_STEPS))
  // A tick without a report never moves the angle.
  `BMMG_ASSERT(a_angle_idle, in_xfer && !in_data.report_due |=> $stable(angle_r))
  // A held result carries the mode that the block currently holds.
  `BMMG_ASSERT(a_mode_led, out_valid_r |-> out_data_r.mode_led == mode_r)
  // A result without a report carries no movement.
  `BMMG_ASSERT(a_no_report_zero, out_valid_r && !out_data_r.report_valid |->
    out_data_r.delta_x == 8'sd0 && out_data_r.delta_y == 8'sd0)

endmodule

>>> rtl/core/bmmg_hold.sv
// Hold timer of one direction button: counts held ticks and yields its gain.
// Depends on bmmg_pkg for widths and the configuration struct.
module bmmg_hold
  import bmmg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              level,
  input  logic              prev_level,
  input  bmmg_cfg_t         cfg,
  output logic [GAIN_W-1:0] gain
);

  logic [STEP_W-1:0] sub_r, sub_nxt, sub_inc, limit;
  logic [GAIN_W-1:0] steps_r, steps_nxt;
  logic [GAIN_W:0]   gain_sum;

  // A step length of zero behaves as one.
  assign limit   = (cfg.ms_per_gain_step == '0) ? STEP_W'(1) : cfg.ms_per_gain_step;
  assign sub_inc = sub_r + STEP_W'(1);

  // Fresh press clears the timer; a held button counts toward the next step.
  always_comb begin
    sub_nxt   = sub_r;
    steps_nxt = steps_r;
    if (level && !prev_level) begin
      sub_nxt   = '0;
      steps_nxt = '0;
    end else if (level) begin
      if (sub_inc >= limit) begin
        sub_nxt = '0;
        if (steps_r != STEPS_MAX) begin
          steps_nxt = steps_r + GAIN_W'(1);
        end
      end else begin
        sub_nxt = sub_inc;
      end
    end
  end

  // Gain of this tick uses the updated step count, capped by configuration.
  assign gain_sum = {1'b0, cfg.start_gain} + {1'b0, steps_nxt};
  assign gain     = (gain_sum > {1'b0, cfg.gain_cap}) ? cfg.gain_cap : gain_sum[GAIN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= '0;
      steps_r <= '0;
    end else if (advance) begin
      sub_r   <= sub_nxt;
      steps_r <= steps_nxt;
    end
  end

endmodule
